// ----- hdl/pcp_pkg.sv -----
`default_nettype none
package pcp_pkg;

   localparam int MAG_W  = 51;   // magnitude of one rotated coordinate
   localparam int NUM_W  = 83;   // focal length times magnitude
   localparam int QUOT_W = 41;   // quotient bits below the clamp point
   localparam int STEP_N = QUOT_W;

   localparam logic [QUOT_W-1:0] QUOT_LIMIT = {1'b1, {(QUOT_W-1){1'b0}}};

   localparam logic [3:0] CSR_ROT_ROW0        = 4'd0;
   localparam logic [3:0] CSR_ROT_ROW1        = 4'd1;
   localparam logic [3:0] CSR_ROT_ROW2        = 4'd2;
   localparam logic [3:0] CSR_FOCAL_LENGTH    = 4'd3;
   localparam logic [3:0] CSR_PRINCIPAL_POINT = 4'd4;
   localparam logic [3:0] CSR_CENTER_XY       = 4'd5;
   localparam logic [3:0] CSR_CENTER_Z        = 4'd6;
   localparam logic [3:0] CSR_IMAGE_SIZE      = 4'd7;

   typedef struct packed {
      logic [2:0][47:0] rot;
      logic [31:0]      focal;
      logic [31:0]      ppx;
      logic [31:0]      ppy;
      logic [31:0]      cx;
      logic [31:0]      cy;
      logic [31:0]      cz;
      logic [15:0]      height;
      logic [15:0]      width;
   } cfg_type;

   typedef struct packed {
      logic [MAG_W-1:0]  rem_x;
      logic [MAG_W-1:0]  rem_y;
      logic [QUOT_W-1:0] num_x;
      logic [QUOT_W-1:0] num_y;
      logic [QUOT_W-1:0] quot_x;
      logic [QUOT_W-1:0] quot_y;
      logic [MAG_W-1:0]  den;
      logic              neg_x;
      logic              neg_y;
      logic              ovf_x;
      logic              ovf_y;
      logic              degen;
   } div_item_type;

endpackage
`default_nettype wire

// ----- hdl/pinhole_camera_projection.sv -----
// Channel  | Dir | Ports          | Payload
// req      | in  | req_t*         | tdata: world_x, world_y, world_z
// rsp      | out | rsp_t*         | tdata: image_u, image_v; tuser: inside_res, degenerate
// csr      | in  | csr_*          | write enable, register index, 64-bit data
//
// One point enters per cycle while the receiver keeps taking results; the pipeline
// has 7 front stages, 41 divide steps (one quotient bit per step) and one output register.
// Reset is synchronous and empties every stage; registers return to identity.
// A stall stops only the stages that are full, so bubbles close up behind it.
`default_nettype none
module pinhole_camera_projection (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // world_x, world_y, world_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // image_u, image_v
   output logic [1:0]       rsp_tuser,   // inside_res, degenerate
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import pcp_pkg::*;

   cfg_type      cfg_ff;
   div_item_type item [STEP_N+1];
   logic         valid [STEP_N+1];
   logic         ready [STEP_N+1];
   logic [31:0]  image_u, image_v;
   logic         inside_res, degenerate;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot    <= {48'h4000_0000_0000, 48'h0000_4000_0000, 48'h0000_0000_4000};
         cfg_ff.focal  <= 32'h0001_0000;
         cfg_ff.ppx    <= '0;
         cfg_ff.ppy    <= '0;
         cfg_ff.cx     <= '0;
         cfg_ff.cy     <= '0;
         cfg_ff.cz     <= '0;
         cfg_ff.height <= '0;
         cfg_ff.width  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROT_ROW0:        cfg_ff.rot[0] <= csr_wdata[47:0];
            CSR_ROT_ROW1:        cfg_ff.rot[1] <= csr_wdata[47:0];
            CSR_ROT_ROW2:        cfg_ff.rot[2] <= csr_wdata[47:0];
            CSR_FOCAL_LENGTH:    cfg_ff.focal  <= csr_wdata[31:0];
            CSR_PRINCIPAL_POINT: begin
               cfg_ff.ppx <= csr_wdata[31:0];
               cfg_ff.ppy <= csr_wdata[63:32];
            end
            CSR_CENTER_XY: begin
               cfg_ff.cx <= csr_wdata[31:0];
               cfg_ff.cy <= csr_wdata[63:32];
            end
            CSR_CENTER_Z:        cfg_ff.cz <= csr_wdata[31:0];
            CSR_IMAGE_SIZE: begin
               cfg_ff.height <= csr_wdata[15:0];
               cfg_ff.width  <= csr_wdata[31:16];
            end
            default: ;
         endcase
      end
   end

   pcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .world_x   (req_tdata[31:0]),
      .world_y   (req_tdata[63:32]),
      .world_z   (req_tdata[95:64]),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_item  (item[0])
   );

   for (genvar s = 0; s < STEP_N; s++) begin : g_div
      pcp_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[s]),
         .in_ready  (ready[s]),
         .in_item   (item[s]),
         .out_valid (valid[s+1]),
         .out_ready (ready[s+1]),
         .out_item  (item[s+1])
      );
   end

   pcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (valid[STEP_N]),
      .in_ready   (ready[STEP_N]),
      .in_item    (item[STEP_N]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .image_u    (image_u),
      .image_v    (image_v),
      .inside_res (inside_res),
      .degenerate (degenerate)
   );

   assign rsp_tdata = {image_v, image_u};
   assign rsp_tuser = {degenerate, inside_res};

endmodule
`default_nettype wire

// ----- hdl/pcp_front.sv -----
`default_nettype none
module pcp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pcp_pkg::cfg_type     cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [31:0]          world_x,
   input  wire logic [31:0]          world_y,
   input  wire logic [31:0]          world_z,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output pcp_pkg::div_item_type     out_item
);
   import pcp_pkg::*;

   localparam int STAGES = 7;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] rdy;
   logic [STAGES-1:0] vin;

   logic signed [32:0]       d_ff [3];
   logic signed [48:0]       prod_ff [3][3];
   logic signed [MAG_W-1:0]  qx_ff, qy_ff, qz_ff;
   logic [MAG_W-1:0]         mx_ff, my_ff, mz4_ff;
   logic                     nx4_ff, ny4_ff, dg4_ff;
   logic [63:0]              p0x_ff, p0y_ff;
   logic [MAG_W-1:0]         p1x_ff, p1y_ff;
   logic [MAG_W-1:0]         mz5_ff;
   logic                     nx5_ff, ny5_ff, dg5_ff;
   logic [NUM_W-1:0]         nx_ff, ny_ff;
   logic [MAG_W-1:0]         mz6_ff;
   logic                     nx6_ff, ny6_ff, dg6_ff;
   div_item_type             item_ff;

   always_comb begin
      rdy[STAGES-1] = ~valid_ff[STAGES-1] | out_ready;
      for (int k = STAGES-2; k >= 0; k--) begin
         rdy[k] = ~valid_ff[k] | rdy[k+1];
      end
      vin = {valid_ff[STAGES-2:0], in_valid};
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) valid_ff[k] <= vin[k];
         end
      end
      // offset from the camera centre
      if (rdy[0]) begin
         d_ff[0] <= $signed({world_x[31], world_x}) - $signed({cfg.cx[31], cfg.cx});
         d_ff[1] <= $signed({world_y[31], world_y}) - $signed({cfg.cy[31], cfg.cy});
         d_ff[2] <= $signed({world_z[31], world_z}) - $signed({cfg.cz[31], cfg.cz});
      end
      if (rdy[1]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(cfg.rot[r][16*c +: 16]) * d_ff[c];
            end
         end
      end
      // x-axis quarter turn: rows 0, -2, 1
      if (rdy[2]) begin
         qx_ff <= prod_ff[0][0] + prod_ff[0][1] + prod_ff[0][2];
         qy_ff <= -(prod_ff[2][0] + prod_ff[2][1] + prod_ff[2][2]);
         qz_ff <= prod_ff[1][0] + prod_ff[1][1] + prod_ff[1][2];
      end
      if (rdy[3]) begin
         mx_ff  <= qx_ff[MAG_W-1] ? $unsigned(-qx_ff) : $unsigned(qx_ff);
         my_ff  <= qy_ff[MAG_W-1] ? $unsigned(-qy_ff) : $unsigned(qy_ff);
         mz4_ff <= qz_ff[MAG_W-1] ? $unsigned(-qz_ff) : $unsigned(qz_ff);
         nx4_ff <= qx_ff[MAG_W-1] ^ qz_ff[MAG_W-1];
         ny4_ff <= qy_ff[MAG_W-1] ^ qz_ff[MAG_W-1];
         dg4_ff <= (qz_ff == '0);
      end
      if (rdy[4]) begin
         p0x_ff <= {32'd0, cfg.focal} * {32'd0, mx_ff[31:0]};
         p0y_ff <= {32'd0, cfg.focal} * {32'd0, my_ff[31:0]};
         p1x_ff <= {19'd0, cfg.focal} * {32'd0, mx_ff[MAG_W-1:32]};
         p1y_ff <= {19'd0, cfg.focal} * {32'd0, my_ff[MAG_W-1:32]};
         mz5_ff <= mz4_ff;
         nx5_ff <= nx4_ff;
         ny5_ff <= ny4_ff;
         dg5_ff <= dg4_ff;
      end
      if (rdy[5]) begin
         nx_ff  <= {19'd0, p0x_ff} + {p1x_ff, 32'd0};
         ny_ff  <= {19'd0, p0y_ff} + {p1y_ff, 32'd0};
         mz6_ff <= mz5_ff;
         nx6_ff <= nx5_ff;
         ny6_ff <= ny5_ff;
         dg6_ff <= dg5_ff;
      end
      // seed the remainder with the bits above the quotient window
      if (rdy[6]) begin
         item_ff.rem_x  <= {9'd0, nx_ff[NUM_W-1:QUOT_W]};
         item_ff.rem_y  <= {9'd0, ny_ff[NUM_W-1:QUOT_W]};
         item_ff.ovf_x  <= {9'd0, nx_ff[NUM_W-1:QUOT_W]} >= mz6_ff;
         item_ff.ovf_y  <= {9'd0, ny_ff[NUM_W-1:QUOT_W]} >= mz6_ff;
         item_ff.num_x  <= nx_ff[QUOT_W-1:0];
         item_ff.num_y  <= ny_ff[QUOT_W-1:0];
         item_ff.quot_x <= '0;
         item_ff.quot_y <= '0;
         item_ff.den    <= mz6_ff;
         item_ff.neg_x  <= nx6_ff;
         item_ff.neg_y  <= ny6_ff;
         item_ff.degen  <= dg6_ff;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/pcp_div_step.sv -----
`default_nettype none
module pcp_div_step (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire pcp_pkg::div_item_type in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output pcp_pkg::div_item_type     out_item
);
   import pcp_pkg::*;

   logic         valid_ff;
   div_item_type item_ff;
   div_item_type item_in;
   logic [MAG_W:0] pre_x, pre_y;
   logic           ge_x, ge_y;

   always_comb begin
      pre_x = {in_item.rem_x, in_item.num_x[QUOT_W-1]};
      pre_y = {in_item.rem_y, in_item.num_y[QUOT_W-1]};
      ge_x  = pre_x >= {1'b0, in_item.den};
      ge_y  = pre_y >= {1'b0, in_item.den};
      item_in        = in_item;
      item_in.rem_x  = ge_x ? MAG_W'(pre_x - {1'b0, in_item.den}) : pre_x[MAG_W-1:0];
      item_in.rem_y  = ge_y ? MAG_W'(pre_y - {1'b0, in_item.den}) : pre_y[MAG_W-1:0];
      item_in.num_x  = {in_item.num_x[QUOT_W-2:0], 1'b0};
      item_in.num_y  = {in_item.num_y[QUOT_W-2:0], 1'b0};
      item_in.quot_x = {in_item.quot_x[QUOT_W-2:0], ge_x};
      item_in.quot_y = {in_item.quot_y[QUOT_W-2:0], ge_y};
   end

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) item_ff <= item_in;
   end

endmodule
`default_nettype wire

// ----- hdl/pcp_back.sv -----
`default_nettype none
module pcp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pcp_pkg::cfg_type     cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire pcp_pkg::div_item_type in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [31:0]               image_u,
   output logic [31:0]               image_v,
   output logic                      inside_res,
   output logic                      degenerate
);
   import pcp_pkg::*;

   logic              valid_ff;
   logic [31:0]       u_ff, v_ff;
   logic              inside_ff, degen_ff;
   logic [QUOT_W-1:0] mag_x, mag_y;
   logic signed [42:0] val_x, val_y, sum_x, sum_y, h_lim, w_lim;
   logic [31:0]       sat_x, sat_y;
   logic              in_bounds;

   function automatic logic [31:0] sat32(input logic signed [42:0] s);
      logic [31:0] r;
      if (s > 43'sd2147483647) r = 32'h7fff_ffff;
      else if (s < -43'sd2147483648) r = 32'h8000_0000;
      else r = s[31:0];
      return r;
   endfunction

   always_comb begin
      mag_x = (in_item.ovf_x || in_item.quot_x > QUOT_LIMIT) ? QUOT_LIMIT : in_item.quot_x;
      mag_y = (in_item.ovf_y || in_item.quot_y > QUOT_LIMIT) ? QUOT_LIMIT : in_item.quot_y;
      val_x = in_item.neg_x ? -$signed({2'b00, mag_x}) : $signed({2'b00, mag_x});
      val_y = in_item.neg_y ? -$signed({2'b00, mag_y}) : $signed({2'b00, mag_y});
      sum_x = val_x + $signed({{11{cfg.ppx[31]}}, cfg.ppx});
      sum_y = val_y + $signed({{11{cfg.ppy[31]}}, cfg.ppy});
      h_lim = $signed({11'd0, cfg.height, 16'd0});
      w_lim = $signed({11'd0, cfg.width, 16'd0});
      sat_x = sat32(sum_x);
      sat_y = sat32(sum_y);
      // test the unsaturated sums
      in_bounds = (sum_x > 43'sd0) && (sum_x < h_lim) && (sum_y > 43'sd0) && (sum_y < w_lim);
   end

   assign in_ready   = ~valid_ff | out_ready;
   assign out_valid  = valid_ff;
   assign image_u    = u_ff;
   assign image_v    = v_ff;
   assign inside_res = inside_ff;
   assign degenerate = degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         u_ff      <= in_item.degen ? 32'd0 : sat_x;
         v_ff      <= in_item.degen ? 32'd0 : sat_y;
         inside_ff <= ~in_item.degen & in_bounds;
         degen_ff  <= in_item.degen;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/pcp_checker.sv -----
`default_nettype none
module pcp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tdata == 64'd0)
      else $error("degenerate beat with nonzero payload");

   a_inside_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tdata[31] && !rsp_tdata[63])
      else $error("inside beat with negative coordinate");

endmodule

bind pinhole_camera_projection pcp_checker u_pcp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ----- tb/pcp_checker.sv -----
`default_nettype none
module pcp_scoreboard
   import pcp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] u;
      logic [31:0] v;
      logic        in_img;
      logic        degen;
   } pixel_type;

   logic [47:0] rot_q [3];
   logic [31:0] focal_q;
   logic [63:0] pp_q;
   logic [63:0] cxy_q;
   logic [31:0] cz_q;
   logic [31:0] size_q;
   pixel_type   pixel_q [$];

   function automatic longint ent16(logic [47:0] row, int k);
      logic signed [15:0] e;
      e = row[16*k +: 16];
      return longint'(e);
   endfunction

   function automatic longint ent32(logic [31:0] x);
      logic signed [31:0] e;
      e = x;
      return longint'(e);
   endfunction

   // quotient rounded toward zero, clamped at 2^40, then offset
   function automatic longint project_axis(longint qa, longint qz, logic [31:0] f,
                                            longint pp);
      logic [127:0] num, quo;
      logic [63:0]  ma, mz;
      longint       val;
      ma  = qa < 0 ? -qa : qa;
      mz  = qz < 0 ? -qz : qz;
      num = {64'd0, ma} * {96'd0, f};
      quo = num / {64'd0, mz};
      if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
      val = longint'(quo[63:0]);
      if ((qa < 0) != (qz < 0)) val = -val;
      return val + pp;
   endfunction

   function automatic logic [31:0] sat32(longint x);
      if (x > 64'sd2147483647) return 32'h7fffffff;
      if (x < -64'sd2147483648) return 32'h80000000;
      return x[31:0];
   endfunction

   function automatic pixel_type project_point(logic [95:0] pt);
      longint d [3];
      longint qx, qy, qz, u, v, h, w;
      pixel_type p;
      d[0] = ent32(pt[31:0]) - ent32(cxy_q[31:0]);
      d[1] = ent32(pt[63:32]) - ent32(cxy_q[63:32]);
      d[2] = ent32(pt[95:64]) - ent32(cz_q);
      qx = 0; qy = 0; qz = 0;
      for (int k = 0; k < 3; k++) begin
         qx += ent16(rot_q[0], k) * d[k];
         qy -= ent16(rot_q[2], k) * d[k];
         qz += ent16(rot_q[1], k) * d[k];
      end
      if (qz == 0) begin
         p = '{32'd0, 32'd0, 1'b0, 1'b1};
         return p;
      end
      u = project_axis(qx, qz, focal_q, ent32(pp_q[31:0]));
      v = project_axis(qy, qz, focal_q, ent32(pp_q[63:32]));
      h = longint'(size_q[15:0]) * 65536;
      w = longint'(size_q[31:16]) * 65536;
      p.u = sat32(u);
      p.v = sat32(v);
      p.in_img = (u > 0 && u < h && v > 0 && v < w);
      p.degen = 1'b0;
      return p;
   endfunction

   always_ff @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rot_q[0] <= 48'd16384;
         rot_q[1] <= 48'd1 << 30;
         rot_q[2] <= 48'd1 << 46;
         focal_q  <= 32'd65536;
         pp_q     <= '0;
         cxy_q    <= '0;
         cz_q     <= '0;
         size_q   <= '0;
         pixel_q.delete();
         fail_count <= 0;
         checked    <= 0;
         pending    <= 0;
      end else begin
         if (req_tvalid && req_tready) pixel_q.push_back(project_point(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            checked <= checked + 1;
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected beat u=%h v=%h flags=%b", $time,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_tdata[31:0] !== want.u || rsp_tdata[63:32] !== want.v ||
                   rsp_tuser[0] !== want.in_img || rsp_tuser[1] !== want.degen) begin
                  $display("%0t: mismatch exp u=%h v=%h in=%b dg=%b got u=%h v=%h in=%b dg=%b",
                           $time, want.u, want.v, want.in_img, want.degen,
                           rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0], rsp_tuser[1]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= pixel_q.size();
         if (csr_we) begin
            case (csr_index)
               CSR_ROT_ROW0:        rot_q[0] <= csr_wdata[47:0];
               CSR_ROT_ROW1:        rot_q[1] <= csr_wdata[47:0];
               CSR_ROT_ROW2:        rot_q[2] <= csr_wdata[47:0];
               CSR_FOCAL_LENGTH:    focal_q  <= csr_wdata[31:0];
               CSR_PRINCIPAL_POINT: pp_q     <= csr_wdata;
               CSR_CENTER_XY:       cxy_q    <= csr_wdata;
               CSR_CENTER_Z:        cz_q     <= csr_wdata[31:0];
               CSR_IMAGE_SIZE:      size_q   <= csr_wdata[31:0];
               default: ;
            endcase
         end
      end
   end

endmodule
`default_nettype wire

// ----- tb/tb_pinhole_camera_projection.sv -----
`default_nettype none
module tb_pinhole_camera_projection;
   import pcp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 49;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [3:0] CSR_UNUSED = 4'd12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   int          fail_count, pending, checked;
   int          cycles = 0;
   int          sent = 0;
   int          phases = 0;
   bit          hold_off = 1'b0;
   logic [31:0] u_chk_cx = '0, u_chk_cy = '0, u_chk_cz = '0;

   pinhole_camera_projection u_top (.*);
   pcp_scoreboard u_chk (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 0;
         if ($urandom_range(0, 49) == 0) gap = $urandom_range(10, 40);
         if (phases % 3 == 1) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock)
      if (csr_we && csr_index == CSR_CENTER_XY) begin
         u_chk_cx <= csr_wdata[31:0];
         u_chk_cy <= csr_wdata[63:32];
      end else if (csr_we && csr_index == CSR_CENTER_Z) begin
         u_chk_cz <= csr_wdata[31:0];
      end

   // points on the camera centre give zero depth
   function automatic logic [31:0] cfg_x();
      return u_chk_cx;
   endfunction
   function automatic logic [31:0] cfg_y();
      return u_chk_cy;
   endfunction
   function automatic logic [31:0] cfg_z();
      return u_chk_cz;
   endfunction

   task automatic write_reg(logic [3:0] idx, logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_point(logic [95:0] pt);
      int gap;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
      if ($urandom_range(0, 59) == 0) gap = $urandom_range(10, 30);
      if (phases % 3 == 1) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pt;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return 32'h7fffffff - $urandom_range(0, 3);
         default: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
      endcase
   endfunction

   function automatic logic [47:0] rand_row();
      logic [47:0] r;
      r = {$urandom(), 16'($urandom())};
      if ($urandom_range(0, 1)) begin
         r = '0;
         r[16*$urandom_range(0, 2) +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
      end
      return r;
   endfunction

   task automatic random_setup(int mode);
      if (mode == 0) begin
         for (int i = 0; i < 3; i++)
            write_reg(CSR_ROT_ROW0 + 4'(i), {$urandom(), $urandom()});
         write_reg(CSR_FOCAL_LENGTH, 64'hffffffff);
         write_reg(CSR_PRINCIPAL_POINT, 64'h7fffffff_80000000);
         write_reg(CSR_CENTER_XY, 64'h80000000_7fffffff);
         write_reg(CSR_CENTER_Z, 64'h00000000_80000000);
         write_reg(CSR_IMAGE_SIZE, 64'hffffffff);
      end else if (mode == 1) begin
         for (int i = 0; i < 3; i++) write_reg(CSR_ROT_ROW0 + 4'(i), 64'hffff_ffff_ffff);
         write_reg(CSR_FOCAL_LENGTH, 64'd0);
         write_reg(CSR_IMAGE_SIZE, 64'd0);
      end else begin
         for (int i = 0; i < 3; i++) write_reg(CSR_ROT_ROW0 + 4'(i), {16'd0, rand_row()});
         write_reg(CSR_FOCAL_LENGTH, {32'd0, $urandom_range(0, 32'h4000000)});
         write_reg(CSR_PRINCIPAL_POINT, {$urandom_range(0, 32'h2000000),
                                         $urandom_range(0, 32'h2000000)});
         write_reg(CSR_CENTER_XY, {rand_coord(), rand_coord()});
         write_reg(CSR_CENTER_Z, {32'd0, rand_coord()});
         write_reg(CSR_IMAGE_SIZE, {32'd0, 16'($urandom_range(0, 16'h0400)),
                                    16'($urandom_range(0, 16'h0400))});
      end
      write_reg(CSR_UNUSED, {$urandom(), $urandom()});
   endtask

   initial begin
      logic [31:0] ext [4];
      ext = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset identity, zero depth, extremes of each field
      send_point({32'h0, 32'h0, 32'h0});
      send_point({32'h0, 32'h0, 32'h00010000});
      send_point({32'h00020000, 32'h00030000, 32'h00010000});
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            send_point({ext[j], ext[i], ext[(i + j) % 4]});
      drain();
      write_reg(CSR_IMAGE_SIZE, {32'd0, 16'd64, 16'd48});
      write_reg(CSR_PRINCIPAL_POINT, {32'h00200000, 32'h00180000});
      write_reg(CSR_FOCAL_LENGTH, 64'h00400000);
      send_point({32'h00010000, 32'h00000000, 32'h00000000});
      send_point({32'h00010000, 32'h00001000, 32'h00000800});
      send_point({32'h00010000, 32'hffff0000, 32'h00100000});
      send_point({32'hffff0000, 32'h00001000, 32'h00000800});

      while (sent < 850) begin
         phases++;
         drain();
         random_setup(phases % 3 == 0 ? 0 : (phases % 7 == 0 ? 1 : 2));
         // fill the pipeline against a stalled receiver once
         if (phases == 2) hold_off = 1'b1;
         for (int n = 0; n < 70; n++) begin
            if ($urandom_range(0, 3) == 0)
               send_point({$urandom(), $urandom(), $urandom()});
            else if ($urandom_range(0, 9) == 0)
               send_point({cfg_z(), cfg_y(), cfg_x()});
            else
               send_point({rand_coord(), rand_coord(), rand_coord()});
         end
      end
      drain();
      $display("Ran %0d points over %0d register settings, %0d results checked.",
               sent, phases + 2, checked);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
